/* src/binary_heap_priority_queue_macros.svh */
// Assertion macros used by the heap queue engine.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Implication or plain property checked on every rising edge outside reset.
`define BHPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define BHPQ_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/bhpq_pkg.sv */
package bhpq_pkg;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_PEEK  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [15:0] EMPTY_DIST = 16'hFFFF;

	typedef struct packed {
		logic [31:0] id;
		logic [15:0] key;
	} entry_t;

	typedef struct packed {
		logic [31:0] id;
		logic [15:0] key;
		logic [8:0]  count;
		logic [1:0]  status;
	} res_t;

	// True when key a belongs above key b in the current order.
	function automatic logic ranks_above(input logic [15:0] a, input logic [15:0] b,
			input logic max_mode);
		ranks_above = max_mode ? (a > b) : (a < b);
	endfunction

endpackage

/* src/bhpq_ram.sv */
module bhpq_ram #(
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  bhpq_pkg::entry_t  wdata,
	input  logic              ra_en,
	input  logic [AW-1:0]     ra_addr,
	output bhpq_pkg::entry_t  ra_data,
	input  logic              rb_en,
	input  logic [AW-1:0]     rb_addr,
	output bhpq_pkg::entry_t  rb_data
);

	bhpq_pkg::entry_t mem_q [DEPTH];
	bhpq_pkg::entry_t ra_q;
	bhpq_pkg::entry_t rb_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (ra_en) begin
			ra_q <= mem_q[ra_addr];
		end
		if (rb_en) begin
			rb_q <= mem_q[rb_addr];
		end
	end

	assign ra_data = ra_q;
	assign rb_data = rb_q;

endmodule

/* src/bhpq_engine.sv */
`include "binary_heap_priority_queue_macros.svh"

module bhpq_engine #(
	parameter int CAPACITY = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             max_mode,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       in_op,
	input  bhpq_pkg::entry_t in_entry,
	output logic             res_valid,
	input  logic             res_ready,
	output bhpq_pkg::res_t   res
);

	localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = AW + 2;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_UP_RD  = 3'd1;
	localparam logic [2:0] S_UP_CMP = 3'd2;
	localparam logic [2:0] S_POP_LD = 3'd3;
	localparam logic [2:0] S_DN_RD  = 3'd4;
	localparam logic [2:0] S_DN_CMP = 3'd5;
	localparam logic [2:0] S_PEEK   = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0]       state_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    pos_q;
	bhpq_pkg::entry_t x_q;
	logic [31:0]      res_id_q;
	logic [15:0]      res_dist_q;
	logic [1:0]       status_q;

	logic             we;
	logic [AW-1:0]    waddr;
	bhpq_pkg::entry_t wdata;
	logic             ra_en;
	logic [AW-1:0]    ra_addr;
	bhpq_pkg::entry_t ra_data;
	logic             rb_en;
	logic [AW-1:0]    rb_addr;
	bhpq_pkg::entry_t rb_data;

	logic [AW-1:0]    pos_m1;
	logic [AW-1:0]    parent;
	logic [XW-1:0]    lft;
	logic [XW-1:0]    rgt;
	logic [XW-1:0]    count_x;
	logic             lft_ok;
	logic             rgt_ok;
	logic             take_l;
	logic             take_r;
	logic [15:0]      best_l_dist;
	logic [CW+8:0]    count_wide;
	logic [CW-1:0]    count_m1;
	logic             sifting;
	logic             push_go;

	bhpq_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.ra_en(ra_en), .ra_addr(ra_addr), .ra_data(ra_data),
		.rb_en(rb_en), .rb_addr(rb_addr), .rb_data(rb_data)
	);

	assign pos_m1   = pos_q - AW'(1);
	assign parent   = pos_m1 >> 1;
	assign lft      = {1'b0, pos_q, 1'b1};
	assign rgt      = lft + XW'(1);
	assign count_x  = XW'(count_q);
	assign count_m1 = count_q - CW'(1);
	assign lft_ok   = lft < count_x;
	assign rgt_ok   = rgt < count_x;

	assign take_l = lft_ok && bhpq_pkg::ranks_above(ra_data.key, x_q.key, max_mode);
	assign best_l_dist = take_l ? ra_data.key : x_q.key;
	assign take_r = rgt_ok && bhpq_pkg::ranks_above(rb_data.key, best_l_dist, max_mode);

	always_comb begin
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = x_q;
		ra_en   = 1'b0;
		ra_addr = '0;
		rb_en   = 1'b0;
		rb_addr = count_m1[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (in_valid && (in_op == bhpq_pkg::OP_POP || in_op == bhpq_pkg::OP_PEEK)) begin
					ra_en = 1'b1;
					rb_en = (in_op == bhpq_pkg::OP_POP);
				end
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					we = 1'b1;
				end else begin
					ra_en   = 1'b1;
					ra_addr = parent;
				end
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (bhpq_pkg::ranks_above(x_q.key, ra_data.key, max_mode)) begin
					wdata = ra_data;
				end
			end
			S_DN_RD: begin
				ra_en   = 1'b1;
				ra_addr = lft[AW-1:0];
				rb_en   = 1'b1;
				rb_addr = rgt[AW-1:0];
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (take_r) begin
					wdata = rb_data;
				end else if (take_l) begin
					wdata = ra_data;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (in_op)
							bhpq_pkg::OP_PUSH: begin
								if (count_q == CW'(CAPACITY)) begin
									state_q <= S_DONE;
								end else begin
									count_q <= count_q + CW'(1);
									state_q <= S_UP_RD;
								end
							end
							bhpq_pkg::OP_POP: begin
								state_q <= (count_q == '0) ? S_DONE : S_POP_LD;
							end
							bhpq_pkg::OP_PEEK: begin
								state_q <= (count_q == '0) ? S_DONE : S_PEEK;
							end
							default: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_UP_RD: begin
					state_q <= (pos_q == '0) ? S_DONE : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (bhpq_pkg::ranks_above(x_q.key, ra_data.key, max_mode)) begin
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_POP_LD: begin
					count_q <= count_m1;
					state_q <= (count_q == CW'(1)) ? S_DONE : S_DN_RD;
				end
				S_DN_RD: begin
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					state_q <= (take_l || take_r) ? S_DN_RD : S_DONE;
				end
				S_PEEK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_id_q   <= '0;
				res_dist_q <= '0;
				status_q   <= bhpq_pkg::ST_OK;
				x_q        <= in_entry;
				pos_q      <= count_q[AW-1:0];
				if (in_op == bhpq_pkg::OP_PUSH && count_q == CW'(CAPACITY)) begin
					status_q <= bhpq_pkg::ST_FULL;
				end
				if (in_op == bhpq_pkg::OP_POP && count_q == '0) begin
					status_q <= bhpq_pkg::ST_EMPTY;
				end
				if ((in_op == bhpq_pkg::OP_POP || in_op == bhpq_pkg::OP_PEEK) &&
						count_q == '0) begin
					res_dist_q <= bhpq_pkg::EMPTY_DIST;
				end
			end
			S_UP_CMP: begin
				if (bhpq_pkg::ranks_above(x_q.key, ra_data.key, max_mode)) begin
					pos_q <= parent;
				end
			end
			S_POP_LD: begin
				res_id_q   <= ra_data.id;
				res_dist_q <= ra_data.key;
				x_q        <= rb_data;
				pos_q      <= '0;
			end
			S_DN_CMP: begin
				if (take_r) begin
					pos_q <= rgt[AW-1:0];
				end else if (take_l) begin
					pos_q <= lft[AW-1:0];
				end
			end
			S_PEEK: begin
				res_id_q   <= ra_data.id;
				res_dist_q <= ra_data.key;
			end
			default: begin
			end
		endcase
	end

	assign count_wide = {9'b0, count_q};
	assign in_ready   = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res.id     = res_id_q;
	assign res.key    = res_dist_q;
	assign res.count  = count_wide[8:0];
	assign res.status = status_q;

	assign sifting = state_q == S_UP_RD || state_q == S_UP_CMP ||
		state_q == S_DN_RD || state_q == S_DN_CMP;
	assign push_go = state_q == S_IDLE && in_valid && in_op == bhpq_pkg::OP_PUSH &&
		count_q != CW'(CAPACITY);

	`BHPQ_NEVER(a_count_range, clk, arst_n, count_q > CW'(CAPACITY), "count exceeds capacity")
	`BHPQ_ASSERT(a_write_state, clk, arst_n, !we || sifting, "heap write outside a sift")
	`BHPQ_ASSERT(a_pos_range, clk, arst_n, !sifting || CW'(pos_q) < count_q, "position beyond fill")
	`BHPQ_ASSERT(a_push_count, clk, arst_n, push_go |=> count_q == $past(count_q) + CW'(1), "no growth")

endmodule

/* src/binary_heap_priority_queue.sv */
// Channel  Direction  tdata (low bit up)                      tuser
// s_*      in         item_id[31:0], item_dist[47:32]         op[1:0]
// m_*      out        out_id, out_dist, entry_count, zero pad status[1:0]
// cfg_*    in         cfg_wdata = max_mode, written when cfg_we high
// One word is taken at a time; s_tready is high only while the engine is idle.
// From acceptance to hand-off: a push climbs, reading the parent then writing, until
// it stops or reaches the root; a pop that leaves entries descends, reading both children
// then writing; peek reads the top; clear and refused operations go to the result state.
// A result waits in the output register while the next word is accepted.
// Reset empties the heap at once and sets min-heap order; no memory clearing pass.
module binary_heap_priority_queue #(
	parameter int CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // item_id[31:0], item_dist[47:32]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // out_id[31:0], out_dist[47:32], entry_count[56:48], zero
	output logic [1:0]  m_tuser    // status[1:0]
);

	logic             max_mode_q;
	logic             res_valid;
	logic             res_ready;
	bhpq_pkg::res_t   res;
	bhpq_pkg::res_t   out_q;
	logic             out_valid_q;
	bhpq_pkg::entry_t in_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_mode_q <= 1'b0;
		end else if (cfg_we) begin
			max_mode_q <= cfg_wdata;
		end
	end

	assign in_entry.id  = s_tdata[31:0];
	assign in_entry.key = s_tdata[47:32];

	bhpq_engine #(.CAPACITY(CAPACITY)) u_engine (
		.clk(clk), .arst_n(arst_n), .max_mode(max_mode_q),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_op(s_tuser), .in_entry(in_entry),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_q.count, out_q.key, out_q.id};
	assign m_tuser  = out_q.status;

endmodule
